>>> hdl/frsm_pkg.sv
package frsm_pkg;
	localparam int NumSectors     = 16;
	localparam int PagesPerSector = 16;
	localparam int PagesTotal     = NumSectors * PagesPerSector;
	localparam int PageW          = $clog2(PagesTotal);
	localparam int SecW           = $clog2(NumSectors);
	localparam int PgSecW         = $clog2(PagesPerSector);
	localparam int CntW           = PageW + 1;
	localparam logic [31:0] HdrFree    = 32'hFFFF_FFFF;
	localparam logic [31:0] HdrDeleted = 32'h0000_0000;

	// apb byte address of the pages_per_slot register
	localparam logic [1:0] RegPagesPerSlot = 2'd0;

	typedef enum logic [1:0] {
		REQ_FIND   = 2'd0,
		REQ_SAVE   = 2'd1,
		REQ_CLEAR  = 2'd2,
		REQ_FORMAT = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_NOSPACE  = 2'd2,
		ST_RESERVED = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_ERASE, S_SCAN, S_RECL_MARK, S_RECL_PROP, S_RECL_ERASE,
		S_WR_OLD, S_WR_NEW, S_COUNT, S_DONE
	} state_t;
endpackage

>>> hdl/frsm_core.sv
module frsm_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [1:0]                    req,
	input  logic [31:0]                   id,
	input  logic [4:0]                    pps,
	output logic                          done,
	output logic [1:0]                    st_out,
	output logic [frsm_pkg::PageW-1:0]    pg_out,
	output logic [frsm_pkg::CntW-1:0]     used_out,
	output logic [frsm_pkg::CntW-1:0]     free_out,
	output logic [frsm_pkg::CntW-1:0]     del_out
);
	import frsm_pkg::*;

	// header memory: one word per page; a sector flagged erased reads as all free
	// and gets real free headers written just before its first header write
	logic [31:0] mem [PagesTotal];
	logic [31:0] rd_q;
	logic [NumSectors-1:0] era_q; // sector erased since last write: header reads as free
	logic [NumSectors-1:0] cand_q;
	logic changed_q;

	state_t state_q, state_d;
	logic [4:0]       ps;
	logic [PageW:0]   page_q;     // current slot start page, one extra bit for end
	logic             ph_q;       // header read issued, data valid in rd_q
	logic [PageW-1:0] fslot_q, eslot_q;
	logic             ffound_q, efound_q, recl_done_q;
	logic [CntW-1:0]  nu_q, nf_q, nd_q;
	logic [1:0]       st_q;
	logic [PageW-1:0] pg_q;
	logic [PgSecW-1:0] fill_q;

	assign ps = (pps == 5'd0) ? 5'd1 : (pps > 5'd16) ? 5'd16 : pps;

	// slot geometry of current slot
	logic [PageW:0]   last_page;
	logic             in_range;
	logic [PageW-1:0] pidx;
	logic [SecW-1:0]  sa, sb;
	logic [31:0]      hdr;
	logic [NumSectors-1:0] span;
	assign last_page = page_q + (PageW+1)'(ps) - 1'b1;
	assign in_range  = last_page < (PageW+1)'(PagesTotal);
	assign pidx      = page_q[PageW-1:0];
	assign sa        = SecW'(pidx / PagesPerSector);
	assign sb        = SecW'(last_page[PageW-1:0] / PagesPerSector);
	assign hdr       = era_q[sa] ? HdrFree : rd_q;
	always_comb begin
		for (int s = 0; s < NumSectors; s++)
			span[s] = (SecW'(s) >= sa) && (SecW'(s) <= sb);
	end

	// sector holding the free slot's header, filled with free headers while flagged
	logic [SecW-1:0]  fsec;
	logic             fill_last;
	logic [PageW-1:0] fill_pg;
	assign fsec      = SecW'(fslot_q / PagesPerSector);
	assign fill_last = fill_q == PgSecW'(PagesPerSector - 1);
	assign fill_pg   = PageW'(fsec) * PageW'(PagesPerSector) + PageW'(fill_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (start) begin
				if (req == REQ_FORMAT) state_d = S_COUNT;
				else if (id == HdrFree || id == HdrDeleted) state_d = S_COUNT;
				else state_d = S_SCAN;
			end
			S_SCAN: if (!in_range) begin
				if (req == REQ_SAVE && !ffound_q && !recl_done_q) state_d = S_RECL_MARK;
				else if (req == REQ_SAVE && ffound_q) begin
					if (efound_q) state_d = S_WR_OLD;
					else state_d = era_q[fsec] ? S_ERASE : S_WR_NEW;
				end
				else if (req == REQ_CLEAR && efound_q) state_d = S_WR_OLD;
				else state_d = S_COUNT;
			end
			S_RECL_MARK:  if (!in_range) state_d = S_RECL_PROP;
			S_RECL_PROP:  if (!in_range && !changed_q) state_d = S_RECL_ERASE;
			S_RECL_ERASE: state_d = S_SCAN;
			S_WR_OLD: begin
				if (req != REQ_SAVE) state_d = S_COUNT;
				else state_d = era_q[fsec] ? S_ERASE : S_WR_NEW;
			end
			S_ERASE:      if (fill_last) state_d = S_WR_NEW;
			S_WR_NEW:     state_d = S_COUNT;
			S_COUNT:      if (!in_range) state_d = S_DONE;
			S_DONE:       state_d = S_IDLE;
			default:      state_d = S_IDLE;
		endcase
	end

	assign done = (state_q == S_DONE);

	// single header write port
	logic             wr_en;
	logic [PageW-1:0] wr_pg;
	logic [31:0]      wr_data;
	always_comb begin
		wr_en   = 1'b0;
		wr_pg   = fill_pg;
		wr_data = HdrFree;
		case (state_q)
			S_ERASE: wr_en = 1'b1;
			S_WR_OLD: begin
				wr_en   = 1'b1;
				wr_pg   = eslot_q;
				wr_data = HdrDeleted;
			end
			S_WR_NEW: begin
				wr_en   = 1'b1;
				wr_pg   = fslot_q;
				wr_data = id;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			era_q   <= '1;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE:       if (start && req == REQ_FORMAT) era_q <= '1;
				S_RECL_ERASE: era_q <= era_q | cand_q;
				S_ERASE:      if (fill_last) era_q[fsec] <= 1'b0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_pg] <= wr_data;
		rd_q <= mem[pidx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q <= '0; ffound_q <= 1'b0; efound_q <= 1'b0; recl_done_q <= 1'b0;
			cand_q <= '0; changed_q <= 1'b0; fslot_q <= '0; eslot_q <= '0;
			nu_q <= '0; nf_q <= '0; nd_q <= '0; st_q <= ST_OK; pg_q <= '0;
			ph_q <= 1'b0; fill_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					page_q <= '0; ffound_q <= 1'b0; efound_q <= 1'b0;
					recl_done_q <= 1'b0; pg_q <= '0;
					nu_q <= '0; nf_q <= '0; nd_q <= '0;
					ph_q <= 1'b0; fill_q <= '0;
					st_q <= (start && req != REQ_FORMAT
						&& (id == HdrFree || id == HdrDeleted)) ? ST_RESERVED : ST_OK;
				end
				S_SCAN: begin
					if (in_range) begin
						if (ph_q) begin
							if (hdr == HdrFree && !ffound_q) begin
								ffound_q <= 1'b1; fslot_q <= pidx;
							end
							if (hdr == id && !efound_q) begin
								efound_q <= 1'b1; eslot_q <= pidx;
							end
							page_q <= page_q + (PageW+1)'(ps);
						end
						ph_q <= !ph_q;
					end else begin
						page_q <= '0;
						case (req)
							REQ_FIND: begin
								if (efound_q) pg_q <= eslot_q; else st_q <= ST_NOTFOUND;
							end
							REQ_SAVE: begin
								if (ffound_q) pg_q <= fslot_q;
								else if (recl_done_q) st_q <= ST_NOSPACE;
								cand_q <= '1;
							end
							REQ_CLEAR: begin
								if (efound_q) pg_q <= eslot_q; else st_q <= ST_NOTFOUND;
							end
							default: ;
						endcase
					end
				end
				S_RECL_MARK: begin
					if (in_range) begin
						if (ph_q) begin
							if (hdr != HdrDeleted) cand_q <= cand_q & ~span;
							page_q <= page_q + (PageW+1)'(ps);
						end
						ph_q <= !ph_q;
					end else begin
						page_q <= '0; changed_q <= 1'b0;
					end
				end
				S_RECL_PROP: begin
					if (in_range) begin
						if ((cand_q & span) != span && (cand_q & span) != '0) begin
							cand_q <= cand_q & ~span; changed_q <= 1'b1;
						end
						page_q <= page_q + (PageW+1)'(ps);
					end else begin
						page_q <= '0; changed_q <= 1'b0;
					end
				end
				S_RECL_ERASE: begin
					recl_done_q <= 1'b1; ffound_q <= 1'b0; efound_q <= 1'b0;
				end
				S_ERASE: begin
					fill_q <= fill_q + 1'b1;
				end
				S_COUNT: begin
					if (in_range) begin
						if (ph_q) begin
							if (hdr == HdrFree) nf_q <= nf_q + 1'b1;
							else if (hdr == HdrDeleted) nd_q <= nd_q + 1'b1;
							else nu_q <= nu_q + 1'b1;
							page_q <= page_q + (PageW+1)'(ps);
						end
						ph_q <= !ph_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign st_out = st_q;
	assign pg_out = pg_q;
	assign used_out = nu_q;
	assign free_out = nf_q;
	assign del_out = nd_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> state_q == S_IDLE) else $error("done not followed by idle");
	a_count_sum: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (nu_q + nf_q + nd_q) <= CntW'(PagesTotal)) else $error("count overflow");
	a_nospace_pg: assert property (@(posedge clk) disable iff (!arst_n)
		(done && st_q != ST_OK) |-> pg_q == '0) else $error("page on failure");
endmodule

>>> hdl/flash_record_slot_manager.sv
// Flash record slot manager. Commands (find, save, clear, format) arrive as
// transfers on req_type/record_id; each gives exactly one result transfer with
// status, page_index and the used/free/deleted slot counts. One command at a
// time: a command walks the slot headers with one shared compare unit (registered
// header read, then compare), so a find or clear takes a search pass plus a count
// pass. A save that must reclaim adds a marking pass, up to seventeen propagation
// passes and a second search. Sector erase is done by per-sector erased flags, so
// reset and format need no clearing sweep; the first header write into an erased
// sector first writes free headers into it. A result waits in an output register;
// the next command is taken once it has gone. pages_per_slot sits at address 0
// of the APB port and must be written only when idle; the block itself does not
// enforce this.
module flash_record_slot_manager (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [31:0] record_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [7:0]  page_index,
	output logic [8:0]  used_slots,
	output logic [8:0]  free_slots,
	output logic [8:0]  deleted_slots
);
	import frsm_pkg::*;

	logic [4:0]  pps_q;
	logic        busy_q;
	logic [1:0]  req_q;
	logic [31:0] id_q;
	logic        start_q;
	logic        done;
	logic [1:0]  st_w;
	logic [PageW-1:0] pg_w;
	logic [CntW-1:0]  nu_w, nf_w, nd_w;

	assign pready = 1'b1;
	// register file: only pages_per_slot at index 0
	assign prdata = (paddr == RegPagesPerSlot) ? {27'd0, pps_q} : 32'd0;

	assign in_ready = !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pps_q <= 5'd1;
			busy_q <= 1'b0;
			start_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (psel && penable && pwrite && paddr == RegPagesPerSlot) pps_q <= pwdata[4:0];
			start_q <= in_valid && in_ready;
			if (in_valid && in_ready) busy_q <= 1'b1;
			if (done) out_valid <= 1'b1;
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
				busy_q <= 1'b0;
			end
		end
	end

	// command and result capture
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q <= req_type;
			id_q  <= record_id;
		end
		if (done) begin
			status <= st_w;
			page_index <= 8'(pg_w);
			used_slots <= 9'(nu_w);
			free_slots <= 9'(nf_w);
			deleted_slots <= 9'(nd_w);
		end
	end

	frsm_core u_core (
		.clk(clk), .arst_n(arst_n), .start(start_q), .req(req_q), .id(id_q),
		.pps(pps_q), .done(done), .st_out(st_w), .pg_out(pg_w),
		.used_out(nu_w), .free_out(nf_w), .del_out(nd_w)
	);

	a_busy_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("ready while result pending");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy_q) else $error("done while idle");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |=> !out_valid) else $error("repeated result");
endmodule
